// ===== design/ovl_pkg.sv =====
// ovl_pkg: shared types, codes and defaults for the ordered value list core
// no dependencies; imported by ovl_datapath, ovl_ctrl and the top level
package ovl_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int DATA_W       = 32;
    localparam int REQ_W        = 2;
    localparam int STAT_W       = 3;

    // request kinds carried on s_axis_tuser
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LIST   = 2'd2;

    // result status carried on m_axis_tuser
    localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STAT_W-1:0] ST_DELETED   = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_ENTRY     = 3'd4;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd5;

    // controller to datapath
    typedef struct packed {
        logic              req_load;   // capture request value
        logic              idx_clr;    // walk index back to head
        logic              idx_inc;    // advance walk index
        logic              wr_en;      // write entry store
        logic              wr_shift;   // write address is index minus one, else count
        logic              cnt_inc;
        logic              cnt_dec;
        logic              emit;       // load output register
        logic [STAT_W-1:0] emit_status;
        logic              emit_entry; // data from the store, else zero
        logic              emit_last;
    } t_ovl_cmd;

    // datapath to controller
    typedef struct packed {
        logic cnt_zero;
        logic cnt_full;
        logic idx_end;   // index has reached the entry count
        logic idx_last;  // index points at the tail entry
        logic match;     // entry at index equals request value
        logic out_free;  // output register can take a result this cycle
    } t_ovl_sts;

endpackage

// ===== design/ovl_ram.sv =====
// ovl_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module ovl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/ovl_datapath.sv =====
// ovl_datapath: entry store, entry count, walk index, compare and output register
// depends on ovl_pkg and ovl_ram
module ovl_datapath #(
    parameter int CAPACITY = ovl_pkg::DEF_CAPACITY
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ovl_pkg::t_ovl_cmd               i_cmd,
    output ovl_pkg::t_ovl_sts               o_sts,
    input  logic [ovl_pkg::DATA_W-1:0]      i_req_value,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [ovl_pkg::STAT_W-1:0]      o_out_status,
    output logic [ovl_pkg::DATA_W-1:0]      o_out_data,
    output logic                            o_out_last
);
    import ovl_pkg::*;

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int RAM_D  = 1 << ADDR_W;

    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [DATA_W-1:0] r_value;
    logic              r_out_valid, n_out_valid;
    logic [STAT_W-1:0] r_out_status;
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_last;

    logic [CNT_W-1:0]  idx_prev;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] rd_data;
    logic              out_free;

    // next index drives the read port so that rd_data is the entry at r_idx
    always_comb begin
        n_idx = r_idx;
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + CNT_W'(1);
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign idx_prev = r_idx - CNT_W'(1);
    assign wr_addr  = i_cmd.wr_shift ? idx_prev[ADDR_W-1:0] : r_count[ADDR_W-1:0];

    ovl_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_D),
        .ADDR_W(ADDR_W)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (i_cmd.wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(i_cmd.wr_shift ? rd_data : r_value),
        .i_rd_addr(n_idx[ADDR_W-1:0]),
        .o_rd_data(rd_data)
    );

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_value <= i_req_value;
        end
        if (i_cmd.emit) begin
            r_out_status <= i_cmd.emit_status;
            r_out_data   <= i_cmd.emit_entry ? rd_data : '0;
            r_out_last   <= i_cmd.emit_last;
        end
    end

    assign o_sts.cnt_zero = (r_count == '0);
    assign o_sts.cnt_full = (r_count == CNT_W'(CAPACITY));
    assign o_sts.idx_end  = (r_idx >= r_count);
    assign o_sts.idx_last = ({1'b0, r_idx} + (CNT_W + 1)'(1)) == {1'b0, r_count};
    assign o_sts.match    = (rd_data == r_value);
    assign o_sts.out_free = out_free;

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_data   = r_out_data;
    assign o_out_last   = r_out_last;

endmodule

// ===== design/ovl_ctrl.sv =====
// ovl_ctrl: request sequencer for insert, delete search and compaction, and listing
// depends on ovl_pkg
module ovl_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    input  logic [ovl_pkg::REQ_W-1:0]  i_req_type,
    output logic                       o_req_ready,
    input  ovl_pkg::t_ovl_sts          i_sts,
    output ovl_pkg::t_ovl_cmd          o_cmd
);
    import ovl_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INS   = 3'd1;
    localparam logic [2:0] S_SRCH  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_LIST  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       accept;

    assign o_req_ready = (r_state == S_IDLE);
    assign accept      = i_req_valid && o_req_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.idx_clr  = 1'b1;
                o_cmd.req_load = accept;
                if (accept) begin
                    case (i_req_type)
                        REQ_INSERT: n_state = S_INS;
                        REQ_DELETE: n_state = S_SRCH;
                        REQ_LIST:   n_state = S_LIST;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_INS: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    n_state         = S_IDLE;
                    if (i_sts.cnt_full) begin
                        o_cmd.emit_status = ST_FULL;
                    end else begin
                        o_cmd.emit_status = ST_INSERTED;
                        o_cmd.wr_en       = 1'b1;
                        o_cmd.cnt_inc     = 1'b1;
                    end
                end
            end
            S_SRCH: begin
                if (i_sts.idx_end) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_status = ST_NOT_FOUND;
                        o_cmd.emit_last   = 1'b1;
                        n_state           = S_IDLE;
                    end
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    if (i_sts.match) begin
                        n_state = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                // each following entry moves down by one place
                if (i_sts.idx_end) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit        = 1'b1;
                        o_cmd.emit_status = ST_DELETED;
                        o_cmd.emit_last   = 1'b1;
                        o_cmd.cnt_dec     = 1'b1;
                        n_state           = S_IDLE;
                    end
                end else begin
                    o_cmd.wr_en    = 1'b1;
                    o_cmd.wr_shift = 1'b1;
                    o_cmd.idx_inc  = 1'b1;
                end
            end
            S_LIST: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.cnt_zero) begin
                        o_cmd.emit_status = ST_EMPTY;
                        o_cmd.emit_last   = 1'b1;
                        n_state           = S_IDLE;
                    end else begin
                        o_cmd.emit_status = ST_ENTRY;
                        o_cmd.emit_entry  = 1'b1;
                        o_cmd.emit_last   = i_sts.idx_last;
                        o_cmd.idx_inc     = 1'b1;
                        if (i_sts.idx_last) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/ordered_value_list_core.sv =====
// ordered_value_list_core: top level of the bounded ordered list of signed values
// depends on ovl_pkg, ovl_ctrl, ovl_datapath (which holds ovl_ram)
//
//   port group | dir | tdata          | tuser             | tlast
//   s_axis     | in  | value [31:0]   | req_type [1:0]    | -
//   m_axis     | out | entry_value    | status [2:0]      | last result of a request
//
// a delete searches, then moves one entry per cycle toward the head; a list gives
// one result per entry or a single empty result; unused request code 3 gives no result
// synchronous active-low reset clears the entry count, the walk index, the sequencer and
// the output valid flag; the entry store is never read before it is written
// a result not taken holds the sequencer in place, which adds the stall to the
// request; a new request is taken once its last result is in the output register
module ordered_value_list_core #(
    parameter int CAPACITY = ovl_pkg::DEF_CAPACITY
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request channel
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic signed [ovl_pkg::DATA_W-1:0]  s_axis_tdata,   // value
    input  logic [ovl_pkg::REQ_W-1:0]          s_axis_tuser,   // req_type
    // result channel
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic signed [ovl_pkg::DATA_W-1:0]  m_axis_tdata,   // entry_value
    output logic [ovl_pkg::STAT_W-1:0]         m_axis_tuser,   // status
    output logic                               m_axis_tlast    // last
);
    import ovl_pkg::*;

    t_ovl_cmd          cmd;
    t_ovl_sts          sts;
    logic [DATA_W-1:0] out_data;

    // sequencer: insert, search, shift, list states; one entry per cycle unless stalled
    ovl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(s_axis_tvalid),
        .i_req_type (s_axis_tuser),
        .o_req_ready(s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // storage, count, walk index, compare and the output register
    ovl_datapath #(
        .CAPACITY(CAPACITY)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req_value (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_status(m_axis_tuser),
        .o_out_data  (out_data),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = out_data;

endmodule

// ===== tb/sv/ordered_value_list_core_test.sv =====
// ordered_value_list_core_test: self-checking bench for the ordered value list core
// depends on ovl_pkg and ordered_value_list_core; keeps a shadow list and checks every result
`timescale 1ns / 1ps

module ordered_value_list_core_test;
    import ovl_pkg::*;

    localparam int CAPACITY   = DEF_CAPACITY;
    localparam int CLK_PERIOD = 12;
    localparam int TIMEOUT_CYCLES = 600_000;

    // request code the core must swallow without a result
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] entry_value;
        logic                     last;
    } t_list_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic signed [DATA_W-1:0]  s_axis_tdata = '0;    // value
    logic [REQ_W-1:0]          s_axis_tuser = '0;    // req_type
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic signed [DATA_W-1:0]  m_axis_tdata;         // entry_value
    logic [STAT_W-1:0]         m_axis_tuser;         // status
    logic                      m_axis_tlast;         // last result of a request

    // shadow copy of the list, updated when a request transaction is accepted
    logic signed [DATA_W-1:0]  shadow_entries [CAPACITY];
    int                        shadow_count = 0;

    // results still owed by the core, oldest first
    t_list_result              awaited_results [$];

    // idle percentages for the request and result sides
    int                        tx_idle_pct = 0;
    int                        rx_idle_pct = 0;

    int                        mismatch_count = 0;
    int                        requests_sent = 0;
    int                        results_checked = 0;
    int                        status_tally [8];

    ordered_value_list_core #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // hard stop in case the core hangs or loses a result
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("timeout at %0t with %0d results outstanding", $time,
                 awaited_results.size());
        $display("FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------

    function automatic void queue_result(input logic [STAT_W-1:0] status,
                                         input logic signed [DATA_W-1:0] value,
                                         input logic last);
        t_list_result r;
        r.status      = status;
        r.entry_value = value;
        r.last        = last;
        awaited_results.push_back(r);
        status_tally[status]++;
    endfunction

    // walks the shadow list the same way the core should and queues the results
    function automatic void predict_list_results(input logic [REQ_W-1:0] req,
                                                 input logic signed [DATA_W-1:0] value);
        int hit;
        int k;
        hit = -1;
        case (req)
            REQ_INSERT: begin
                if (shadow_count >= CAPACITY) begin
                    queue_result(ST_FULL, '0, 1'b1);
                end else begin
                    shadow_entries[shadow_count] = value;
                    shadow_count++;
                    queue_result(ST_INSERTED, '0, 1'b1);
                end
            end
            REQ_DELETE: begin
                // first match from the head wins
                for (k = 0; k < shadow_count && hit < 0; k++) begin
                    if (shadow_entries[k] == value) hit = k;
                end
                if (hit < 0) begin
                    queue_result(ST_NOT_FOUND, '0, 1'b1);
                end else begin
                    // close the gap toward the head
                    for (k = hit; k + 1 < shadow_count; k++) begin
                        shadow_entries[k] = shadow_entries[k + 1];
                    end
                    shadow_count--;
                    queue_result(ST_DELETED, '0, 1'b1);
                end
            end
            REQ_LIST: begin
                if (shadow_count == 0) begin
                    queue_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (k = 0; k < shadow_count; k++) begin
                        queue_result(ST_ENTRY, shadow_entries[k], k + 1 == shadow_count);
                    end
                end
            end
            default: ;  // unused code: no result, no change
        endcase
    endfunction

    // ---------------------------------------------------------------
    // result side: random backpressure and the checker
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // every accepted result transaction is matched against the oldest expectation
    always @(posedge i_clk) begin
        t_list_result exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, actual status %0d value %0d last %0b",
                         $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
            end else begin
                exp_r = awaited_results.pop_front();
                results_checked++;
                if (m_axis_tuser !== exp_r.status) begin
                    mismatch_count++;
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_r.status, m_axis_tuser);
                end
                if (m_axis_tdata !== exp_r.entry_value) begin
                    mismatch_count++;
                    $display("%0t: entry_value expected %0d actual %0d", $time,
                             exp_r.entry_value, m_axis_tdata);
                end
                if (m_axis_tlast !== exp_r.last) begin
                    mismatch_count++;
                    $display("%0t: last expected %0b actual %0b", $time,
                             exp_r.last, m_axis_tlast);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------

    // one request transaction, with an optional random gap in front of it;
    // called and returning at a rising edge
    task automatic send_request(input logic [REQ_W-1:0] req,
                                input logic signed [DATA_W-1:0] value);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            // idle with junk on the bus, valid low
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            s_axis_tuser  <= REQ_W'($urandom_range(0, 3));
            @(posedge i_clk);
            while ($urandom_range(0, 99) < tx_idle_pct) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= req;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_list_results(req, value);
        requests_sent++;
    endtask

    // holds the request side off until the core has delivered everything owed
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
    endtask

    // values: deletes mostly reuse listed entries, else a small set, full-range and corners
    function automatic logic signed [DATA_W-1:0] pick_value(input bit for_delete);
        logic signed [DATA_W-1:0] v;
        if (for_delete && shadow_count > 0 && $urandom_range(0, 99) < 70) begin
            v = shadow_entries[$urandom_range(0, shadow_count - 1)];
        end else begin
            case ($urandom_range(0, 2))
                0: v = $urandom;
                1: v = $signed($urandom_range(0, 6)) - 3;
                default: begin
                    case ($urandom_range(0, 3))
                        0: v = 32'sh8000_0000;
                        1: v = 32'sh7fff_ffff;
                        2: v = '0;
                        default: v = -1;
                    endcase
                end
            endcase
        end
        return v;
    endfunction

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // requests on an empty list, the unused code, and a one-entry delete
    task automatic test_empty_list();
        send_request(REQ_LIST, 32'sd0);
        send_request(REQ_DELETE, 32'sd5);
        send_request(REQ_UNUSED, 32'sh7fff_ffff);
        send_request(REQ_INSERT, 32'sd42);
        send_request(REQ_DELETE, 32'sd42);
    endtask

    // fill to capacity with corner values and a duplicate, then overflow and list
    task automatic test_fill_to_capacity();
        logic signed [DATA_W-1:0] fill_vals [CAPACITY];
        int k;
        fill_vals = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, -32'sd1,
                      32'sh5555_5555, 32'shaaaa_aaaa, 32'sd1, 32'sd7,
                      32'sh1234_5678, 32'sd7, -32'sd2, 32'shdead_beef,
                      32'sh0f0f_0f0f, 32'shf0f0_f0f0, 32'sd100, 32'sh7fff_fffe};
        for (k = 0; k < CAPACITY; k++) send_request(REQ_INSERT, fill_vals[k]);
        send_request(REQ_INSERT, 32'sd9);
        send_request(REQ_LIST, 32'sd0);
    endtask

    // delete at the head, first of two duplicates, and a miss, then list
    task automatic test_delete_cases();
        send_request(REQ_DELETE, 32'sh8000_0000);
        send_request(REQ_DELETE, 32'sd7);
        send_request(REQ_DELETE, 32'sd99);
        send_request(REQ_LIST, 32'sd0);
    endtask

    // random traffic in alternating fill-heavy and drain-heavy stretches
    task automatic test_random_traffic(input int n_requests, input int tx_pct,
                                       input int rx_pct);
        int counted;
        int pick;
        bit fill_bias;
        logic [REQ_W-1:0] req;
        counted = 0;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        while (counted < n_requests) begin
            fill_bias = ((counted / 24) % 2) == 0;
            pick = $urandom_range(0, 99);
            if (pick < (fill_bias ? 60 : 25))      req = REQ_INSERT;
            else if (pick < (fill_bias ? 80 : 75)) req = REQ_DELETE;
            else if (pick < 95)                    req = REQ_LIST;
            else                                   req = REQ_UNUSED;
            send_request(req, pick_value(req == REQ_DELETE));
            if (req != REQ_UNUSED) counted++;
            // one full drain halfway through
            if (counted == n_requests / 2 && req != REQ_UNUSED) wait_results_drained();
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 37;
        rx_idle_pct = 51;
        test_empty_list();
        test_fill_to_capacity();
        test_delete_cases();
        wait_results_drained();

        test_random_traffic(140, 37, 51);
        test_random_traffic(140, 51, 37);
        test_random_traffic(140, 0, 0);

        // let everything owed arrive, then watch for strays
        wait_results_drained();
        repeat (2 * CAPACITY + 8) @(posedge i_clk);

        $display("sent %0d requests, checked %0d results: %0d inserted, %0d full,",
                 requests_sent, results_checked, status_tally[ST_INSERTED],
                 status_tally[ST_FULL]);
        $display("%0d deleted, %0d not found, %0d listed entries, %0d empty; %0d mismatches",
                 status_tally[ST_DELETED], status_tally[ST_NOT_FOUND],
                 status_tally[ST_ENTRY], status_tally[ST_EMPTY], mismatch_count);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
